// ----- sv/bsss_pkg.sv -----
// Package for the binary sequence sidelobe scorer.
// Holds the channel payload types, the per-cell pipeline record and shared widths.
// No dependencies.
package bsss_pkg;

  localparam int unsigned SEQ_W    = 64;
  localparam int unsigned LEN_W    = 7;
  localparam int unsigned PEAK_W   = 6;
  localparam int unsigned ENERGY_W = 17;
  localparam int unsigned IDX_W    = 1;

  localparam logic [IDX_W-1:0] CFG_SEQ_LENGTH     = 1'b0;
  localparam logic [IDX_W-1:0] CFG_PEAK_THRESHOLD = 1'b1;

  localparam logic [LEN_W-1:0] SEQ_LENGTH_RST     = 7'd64;
  localparam logic [LEN_W-1:0] PEAK_THRESHOLD_RST = 7'd64;

  typedef struct packed {
    logic [SEQ_W-1:0] candidate;
  } in_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]    sequence_res;
    logic [PEAK_W-1:0]   peak_sidelobe;
    logic [ENERGY_W-1:0] sidelobe_energy;
  } out_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [LEN_W-1:0] data;
  } cfg_item_t;

  // Record handed from one lag cell to the next.
  typedef struct packed {
    logic                valid;
    logic [SEQ_W-1:0]    seq;
    logic [PEAK_W-1:0]   peak;
    logic [ENERGY_W-1:0] energy;
    logic [PEAK_W-1:0]   mag;
  } cell_t;

endpackage

// ----- sv/bsss_stream_if.sv -----
// Valid/ready channel interface used by the scorer ports.
// Carries one payload of the type given as parameter; no dependencies.
interface bsss_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/binary_sequence_sidelobe_scorer_unit.sv -----
// Binary sequence sidelobe scorer: a chain of MAX_BITS-1 lag cells.
// Pipeline: input register, one cell per lag, then an output register.
// Throughput is one candidate per cycle; the whole chain holds while a result waits.
// Reset clears all valid flags and sets seq_length and peak_threshold to 64.
// Depends on bsss_pkg, bsss_stream_if and bsss_cell.
module binary_sequence_sidelobe_scorer_unit #(
  parameter int unsigned MAX_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bsss_stream_if.sink   cfg_i,
  bsss_stream_if.sink   in_i,
  bsss_stream_if.source out_o
);
  import bsss_pkg::*;

  localparam int unsigned NCELL = MAX_BITS - 1;

  logic [LEN_W-1:0]    seq_length_q;
  logic [LEN_W-1:0]    peak_threshold_q;
  logic [LEN_W-1:0]    len_eff;
  logic [SEQ_W-1:0]    len_mask;
  logic                advance;
  cell_t               chain [0:NCELL];
  cell_t               head_d;
  cell_t               head_q;
  logic [PEAK_W-1:0]   peak_f;
  logic [2*PEAK_W-1:0] sq_f;
  logic [ENERGY_W-1:0] energy_f;
  logic                out_valid_d;
  logic                out_valid_q;
  out_item_t           out_item_d;
  out_item_t           out_item_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_length_q     <= SEQ_LENGTH_RST;
      peak_threshold_q <= PEAK_THRESHOLD_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_SEQ_LENGTH:     seq_length_q     <= cfg_i.payload.data;
        CFG_PEAK_THRESHOLD: peak_threshold_q <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  assign len_eff = (seq_length_q > LEN_W'(MAX_BITS)) ? LEN_W'(MAX_BITS) : seq_length_q;
  assign advance = !out_valid_q || out_o.ready;
  assign in_i.ready = advance;

  always_comb begin
    for (int i = 0; i < int'(SEQ_W); i++) begin
      len_mask[i] = (LEN_W'(i) < len_eff);
    end
    head_d        = '0;
    head_d.valid  = in_i.valid;
    head_d.seq    = in_i.payload.candidate & len_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
    end else if (advance) begin
      head_q <= head_d;
    end
  end

  assign chain[0] = head_q;

  for (genvar k = 1; k <= NCELL; k++) begin : g_cell
    bsss_cell #(
      .K(k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .advance_i (advance),
      .len_i     (len_eff),
      .cell_i    (chain[k-1]),
      .cell_o    (chain[k])
    );
  end

  always_comb begin
    peak_f   = (chain[NCELL].mag > chain[NCELL].peak) ? chain[NCELL].mag : chain[NCELL].peak;
    sq_f     = chain[NCELL].mag * chain[NCELL].mag;
    energy_f = chain[NCELL].energy + {{(ENERGY_W-2*PEAK_W){1'b0}}, sq_f};
    out_valid_d = chain[NCELL].valid && ({1'b0, peak_f} <= peak_threshold_q);
    out_item_d.sequence_res    = chain[NCELL].seq;
    out_item_d.peak_sidelobe   = peak_f;
    out_item_d.sidelobe_energy = energy_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

endmodule

// ----- sv/bsss_cell.sv -----
// One lag cell of the scorer chain: correlates the sequence at lag K and folds
// the magnitude of the previous lag into the running peak and energy.
// Depends on bsss_pkg.
module bsss_cell #(
  parameter int unsigned K = 1
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      advance_i,
  input  logic [bsss_pkg::LEN_W-1:0] len_i,
  input  bsss_pkg::cell_t           cell_i,
  output bsss_pkg::cell_t           cell_o
);
  import bsss_pkg::*;

  logic [LEN_W-1:0]          agree_cnt;
  logic [LEN_W-1:0]          overlap;
  logic signed [LEN_W:0]     corr;
  logic signed [LEN_W:0]     corr_abs;
  logic [PEAK_W-1:0]         mag;
  logic [2*PEAK_W-1:0]       sq;
  cell_t                     cell_d;
  cell_t                     cell_q;

  always_comb begin
    agree_cnt = '0;
    for (int i = 0; i < int'(SEQ_W - K); i++) begin
      if (LEN_W'(i + K) < len_i) begin
        agree_cnt = agree_cnt + {{(LEN_W-1){1'b0}}, ~(cell_i.seq[i] ^ cell_i.seq[i+K])};
      end
    end
    overlap  = len_i - LEN_W'(K);
    corr     = $signed({agree_cnt, 1'b0}) - $signed({1'b0, overlap});
    corr_abs = (corr < 0) ? -corr : corr;
    mag      = (LEN_W'(K) < len_i) ? corr_abs[PEAK_W-1:0] : '0;
    sq       = cell_i.mag * cell_i.mag;

    cell_d        = cell_i;
    cell_d.mag    = mag;
    cell_d.peak   = (cell_i.mag > cell_i.peak) ? cell_i.mag : cell_i.peak;
    cell_d.energy = cell_i.energy + {{(ENERGY_W-2*PEAK_W){1'b0}}, sq};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cell_q <= '0;
    end else if (advance_i) begin
      cell_q <= cell_d;
    end
  end

  assign cell_o = cell_q;

endmodule
